// ===== rtl/core/seyrb_pkg.sv =====
// ----------------------------------------------------------------------------
// seyrb_pkg
// Shared types and codes for the stereo eye reorder buffer.
// ----------------------------------------------------------------------------
package seyrb_pkg;

	localparam int TIME_W = 48;
	localparam int TAG_W  = 32;
	localparam int CMD_W  = 2;
	localparam int EYE_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	// eye codes (stored eye is one bit: left or right)
	localparam logic EYE_LEFT  = 1'b0;
	localparam logic EYE_RIGHT = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] frame_time;
		logic              eye;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_ROTATE
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		entry_t   new_entry;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

endpackage

// ===== rtl/core/seyrb_in_if.sv =====
// ----------------------------------------------------------------------------
// seyrb_in_if
// Input channel: commands and frame tags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface seyrb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [47:0] frame_time;
	logic [1:0]  eye;
	logic [31:0] payload_tag;

	modport source (
		output valid, command, frame_time, eye, payload_tag,
		input  ready
	);
	modport sink (
		input  valid, command, frame_time, eye, payload_tag,
		output ready
	);
endinterface

// ===== rtl/core/seyrb_out_if.sv =====
// ----------------------------------------------------------------------------
// seyrb_out_if
// Output channel: emitted frame tags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface seyrb_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] out_time;
	logic [1:0]  out_eye;
	logic [31:0] out_tag;
	logic        overflow;
	logic        last_of_run;

	modport source (
		output valid, out_time, out_eye, out_tag, overflow, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_time, out_eye, out_tag, overflow, last_of_run,
		output ready
	);
endinterface

// ===== rtl/core/seyrb_cell.sv =====
// ----------------------------------------------------------------------------
// seyrb_cell
// One slot of the sorted store. Holds a frame, compares it against the
// incoming frame and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module seyrb_cell (
	input  logic                clk,
	input  seyrb_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                is_tail,
	input  logic                prev_after,
	input  seyrb_pkg::entry_t   prev_entry,
	input  seyrb_pkg::entry_t   next_entry,
	input  seyrb_pkg::entry_t   front_entry,
	output logic                after,
	output seyrb_pkg::entry_t   entry
);
	import seyrb_pkg::*;

	entry_t entry_q;

	// new frame sorts behind this one (ties keep arrival order)
	assign after = occupied &&
		((entry_q.frame_time < ctrl.new_entry.frame_time) ||
		 ((entry_q.frame_time == ctrl.new_entry.frame_time) &&
		  (entry_q.eye <= ctrl.new_entry.eye)));

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (!after) begin
					entry_q <= prev_after ? ctrl.new_entry : prev_entry;
				end
			end
			OP_POP: entry_q <= next_entry;
			OP_ROTATE: entry_q <= is_tail ? front_entry : next_entry;
			default: entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule

// ===== rtl/core/stereo_eye_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// stereo_eye_reorder_buffer
// Reorders stereo frame tags so that left and right eyes alternate in time.
// ----------------------------------------------------------------------------
// A frame tag is accepted only while the block is idle and the output
// register is free. Pass-through frames and the first left frame after a
// clear load their result into the output register at the accept edge. Any
// other frame is inserted into a chain of CAPACITY+1 sorting cells at the
// accept edge; the block then pops the chain front into the output register
// for each emitted frame, as long as the front is in sequence or the store
// is over capacity, and goes back to idle once no further frame follows. A
// flush emits every stored frame in order, rotating the chain once around.
// Every result goes through a single output register, so a stalled output
// stalls the chain. A clear produces nothing.
// ----------------------------------------------------------------------------
module stereo_eye_reorder_buffer #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	seyrb_in_if.sink    frames,
	seyrb_out_if.source results
);
	import seyrb_pkg::*;

	localparam int DEPTH = CAPACITY + 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  flush_left_q;
	logic              have_last_q;
	logic [TIME_W-1:0] last_time_q;
	logic              last_eye_q;

	logic              out_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic [EYE_W-1:0]  out_eye_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              overflow_q;
	logic              last_of_run_q;

	cell_ctrl_t ctrl;
	cell_op_t   cell_op;
	entry_t     cell_entry [DEPTH];
	logic       cell_after [DEPTH];
	entry_t     front, second;

	logic accept, out_free, direct, seq, over, more;

	logic              ld;
	logic [TIME_W-1:0] ld_time;
	logic [EYE_W-1:0]  ld_eye;
	logic [TAG_W-1:0]  ld_tag;
	logic              ld_ov;
	logic              ld_last;
	logic              upd_last;
	logic              cnt_inc, cnt_dec, do_clear;

	assign out_free = !out_valid_q || results.ready;
	assign accept   = frames.valid && frames.ready;
	assign front    = cell_entry[0];
	assign second   = cell_entry[1];

	// frames that bypass the store
	assign direct = frames.eye[1] || (!have_last_q && (frames.eye[0] == EYE_LEFT));

	assign seq = have_last_q && (count_q != '0) &&
		(((front.frame_time == last_time_q) && (front.eye == EYE_RIGHT) &&
		  (last_eye_q == EYE_LEFT)) ||
		 ((front.frame_time > last_time_q) && (front.eye == EYE_LEFT) &&
		  (last_eye_q == EYE_RIGHT)));
	assign over = count_q > CNT_W'(CAPACITY);

	// will another frame follow once the front has gone out
	assign more = ((count_q > CNT_W'(1)) &&
		(((second.frame_time == front.frame_time) && (second.eye == EYE_RIGHT) &&
		  (front.eye == EYE_LEFT)) ||
		 ((second.frame_time > front.frame_time) && (second.eye == EYE_LEFT) &&
		  (front.eye == EYE_RIGHT)))) ||
		((count_q - CNT_W'(1)) > CNT_W'(CAPACITY));

	assign ctrl = {cell_op, frames.frame_time, frames.eye[0], frames.payload_tag};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			entry_t prev_e, next_e;
			logic   prev_a;
			if (gi == 0) begin : g_head
				assign prev_e = cell_entry[gi];
				assign prev_a = 1'b1;
			end else begin : g_body
				assign prev_e = cell_entry[gi-1];
				assign prev_a = cell_after[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_end
				assign next_e = cell_entry[gi];
			end else begin : g_mid
				assign next_e = cell_entry[gi+1];
			end
			seyrb_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (count_q > CNT_W'(gi)),
				.is_tail     (count_q == CNT_W'(gi + 1)),
				.prev_after  (prev_a),
				.prev_entry  (prev_e),
				.next_entry  (next_e),
				.front_entry (front),
				.after       (cell_after[gi]),
				.entry       (cell_entry[gi])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (frames.command == CMD_FRAME) && !direct) begin
					state_d = ST_DRAIN;
				end else if (accept && (frames.command == CMD_FLUSH) && (count_q != '0)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_DRAIN: begin
				if (!(seq || over)) begin
					state_d = ST_IDLE;
				end else if (out_free && !more) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free && (flush_left_q == CNT_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		frames.ready = 1'b0;
		cell_op      = OP_HOLD;
		ld           = 1'b0;
		ld_time      = front.frame_time;
		ld_eye       = {1'b0, front.eye};
		ld_tag       = front.tag;
		ld_ov        = 1'b0;
		ld_last      = 1'b0;
		upd_last     = 1'b0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		do_clear     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frames.ready = out_free;
				if (accept) begin
					case (frames.command)
						CMD_FRAME: begin
							if (direct) begin
								ld       = 1'b1;
								ld_time  = frames.frame_time;
								ld_eye   = frames.eye;
								ld_tag   = frames.payload_tag;
								ld_last  = 1'b1;
								upd_last = !frames.eye[1];
							end else begin
								cell_op = OP_INSERT;
								cnt_inc = 1'b1;
							end
						end
						CMD_CLEAR: do_clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if ((seq || over) && out_free) begin
					ld       = 1'b1;
					ld_ov    = !seq;
					ld_last  = !more;
					upd_last = 1'b1;
					cell_op  = OP_POP;
					cnt_dec  = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_last = flush_left_q == CNT_W'(1);
					cell_op = OP_ROTATE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			flush_left_q <= '0;
			have_last_q  <= 1'b0;
			last_time_q  <= '0;
			last_eye_q   <= EYE_LEFT;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				count_q     <= '0;
				have_last_q <= 1'b0;
			end else if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (state_q == ST_IDLE) begin
				flush_left_q <= count_q;
			end else if (ctrl.op == OP_ROTATE) begin
				flush_left_q <= flush_left_q - CNT_W'(1);
			end
			if (upd_last) begin
				have_last_q <= 1'b1;
				last_time_q <= ld_time;
				last_eye_q  <= ld_eye[0];
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_time_q    <= ld_time;
			out_eye_q     <= ld_eye;
			out_tag_q     <= ld_tag;
			overflow_q    <= ld_ov;
			last_of_run_q <= ld_last;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_time    = out_time_q;
	assign results.out_eye     = out_eye_q;
	assign results.out_tag     = out_tag_q;
	assign results.overflow    = overflow_q;
	assign results.last_of_run = last_of_run_q;

endmodule

// ===== tb/sv/stereo_eye_reorder_buffer_test.sv =====
// ----------------------------------------------------------------------------
// stereo_eye_reorder_buffer_test
// Self-checking testbench for the stereo eye reorder buffer.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, every command, pass-through
// eye codes, the first left frame after a clear, ties and flushes. Random
// stereo runs follow: left/right pairs with local reordering and dropped
// frames, fill bursts that push the store past capacity, and noise. Every
// accepted transaction updates an internal sorted-store predictor whose
// results are compared field by field against the output channel, under
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module stereo_eye_reorder_buffer_test;
	import seyrb_pkg::*;

	localparam int STORE_CAP      = 32;
	localparam int ITEM_TARGET    = 490;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;

	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam logic [EYE_W-1:0] EYE_IN_LEFT  = 2'd0;
	localparam logic [EYE_W-1:0] EYE_IN_RIGHT = 2'd1;
	localparam logic [EYE_W-1:0] EYE_IN_OTHER = 2'd2;
	localparam logic [EYE_W-1:0] EYE_IN_ODD   = 2'd3;

	localparam logic [TIME_W-1:0] T_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [TAG_W-1:0]  TAG_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [TIME_W-1:0] frame_time;
		logic [EYE_W-1:0]  eye;
		logic [TAG_W-1:0]  tag;
		logic              overflow;
		logic              last_of_run;
	} emitted_frame_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TIME_W-1:0] frame_time;
		logic [EYE_W-1:0]  eye;
		logic [TAG_W-1:0]  tag;
		logic              typed;
		emitted_frame_t    want;
	} stim_row_t;

	localparam emitted_frame_t NO_WANT = '0;

	// typed rows cause exactly one result that is obvious from the inputs
	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{CMD_CLEAR,    48'd0,  EYE_IN_LEFT,  32'd0,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd0,  EYE_IN_LEFT,  32'd0,   1'b1,
			'{48'd0, EYE_IN_LEFT, 32'd0, 1'b0, 1'b1}},
		'{CMD_FRAME,    T_MAX,  EYE_IN_OTHER, TAG_MAX, 1'b1,
			'{T_MAX, EYE_IN_OTHER, TAG_MAX, 1'b0, 1'b1}},
		'{CMD_FRAME,    48'h5555_5555_5555, EYE_IN_ODD, 32'hAAAA_AAAA, 1'b1,
			'{48'h5555_5555_5555, EYE_IN_ODD, 32'hAAAA_AAAA, 1'b0, 1'b1}},
		'{CMD_RESERVED, T_MAX,  EYE_IN_ODD,   TAG_MAX, 1'b0, NO_WANT},
		'{CMD_FRAME,    48'd0,  EYE_IN_RIGHT, 32'd1,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd1,  EYE_IN_LEFT,  32'd2,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd5,  EYE_IN_RIGHT, 32'd3,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd5,  EYE_IN_LEFT,  32'd4,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd1,  EYE_IN_RIGHT, 32'd5,   1'b0, NO_WANT},
		'{CMD_FLUSH,    48'd0,  EYE_IN_LEFT,  32'd0,   1'b0, NO_WANT},
		'{CMD_FRAME,    T_MAX,  EYE_IN_RIGHT, 32'd6,   1'b0, NO_WANT},
		'{CMD_FRAME,    T_MAX,  EYE_IN_RIGHT, 32'd7,   1'b0, NO_WANT},
		'{CMD_FRAME,    T_MAX,  EYE_IN_LEFT,  32'd8,   1'b0, NO_WANT},
		'{CMD_FLUSH,    T_MAX,  EYE_IN_OTHER, TAG_MAX, 1'b0, NO_WANT},
		'{CMD_CLEAR,    T_MAX,  EYE_IN_ODD,   TAG_MAX, 1'b0, NO_WANT},
		'{CMD_FRAME,    48'd10, EYE_IN_RIGHT, 32'd9,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd20, EYE_IN_LEFT,  32'd10,  1'b1,
			'{48'd20, EYE_IN_LEFT, 32'd10, 1'b0, 1'b1}},
		'{CMD_FRAME,    48'd10, EYE_IN_LEFT,  32'd11,  1'b0, NO_WANT},
		'{CMD_FLUSH,    48'd0,  EYE_IN_LEFT,  32'd0,   1'b0, NO_WANT},
		'{CMD_FRAME,    48'd20, EYE_IN_RIGHT, 32'd12,  1'b0, NO_WANT},
		'{CMD_CLEAR,    48'd0,  EYE_IN_LEFT,  32'd0,   1'b0, NO_WANT},
		'{CMD_FRAME,    T_MAX - 48'd1, EYE_IN_LEFT, 32'd0, 1'b1,
			'{T_MAX - 48'd1, EYE_IN_LEFT, 32'd0, 1'b0, 1'b1}},
		'{CMD_FRAME,    T_MAX - 48'd1, EYE_IN_RIGHT, TAG_MAX, 1'b0, NO_WANT},
		'{CMD_FRAME,    T_MAX,  EYE_IN_LEFT,  32'd13,  1'b0, NO_WANT}
	};

	logic clk;
	logic arst_n;

	seyrb_in_if  frames();
	seyrb_out_if results();

	stereo_eye_reorder_buffer #(
		.CAPACITY(STORE_CAP)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frames  (frames.sink),
		.results (results.source)
	);

	// predictor state
	entry_t            frame_store[$];
	bit                have_last;
	logic [TIME_W-1:0] last_time;
	logic              last_eye;
	emitted_frame_t    step_out[$];
	emitted_frame_t    expected_frames[$];

	int send_idle_pct = 29;
	int recv_idle_pct = 48;
	bit hold_go       = 1'b0;
	bit hold_done     = 1'b0;
	int hold_count    = 0;
	int idle_cycles   = 0;

	int n_items    = 0;
	int n_clears   = 0;
	int n_flushes  = 0;
	int n_results  = 0;
	int n_overflow = 0;
	int n_errors   = 0;

	logic [TIME_W-1:0] cur_time;
	emitted_frame_t    got;
	emitted_frame_t    want;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got_v,
			input logic [63:0] want_v);
		if (got_v !== want_v)
			report_error($sformatf("%s mismatch: got %h, expected %h", name, got_v, want_v));
	endtask

	function automatic bit front_in_sequence();
		if (frame_store.size() == 0 || !have_last)
			return 1'b0;
		if (frame_store[0].frame_time == last_time && frame_store[0].eye == EYE_RIGHT &&
				last_eye == EYE_LEFT)
			return 1'b1;
		if (frame_store[0].frame_time > last_time && frame_store[0].eye == EYE_LEFT &&
				last_eye == EYE_RIGHT)
			return 1'b1;
		return 1'b0;
	endfunction

	// works out the results of one accepted transaction into step_out
	function automatic void predict_reorder(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] t, input logic [EYE_W-1:0] eye,
			input logic [TAG_W-1:0] tag);
		entry_t head;
		int     pos;
		bit     in_seq;
		step_out.delete();
		case (cmd)
			CMD_CLEAR: begin
				frame_store.delete();
				have_last = 1'b0;
			end
			CMD_FLUSH: begin
				foreach (frame_store[i])
					step_out.insert(step_out.size(),
						emitted_frame_t'{frame_store[i].frame_time,
						{1'b0, frame_store[i].eye}, frame_store[i].tag, 1'b0, 1'b0});
			end
			CMD_FRAME: begin
				if (eye == EYE_IN_OTHER || eye == EYE_IN_ODD) begin
					step_out.insert(step_out.size(), emitted_frame_t'{t, eye, tag, 1'b0, 1'b0});
				end else if (!have_last && eye == EYE_IN_LEFT) begin
					step_out.insert(step_out.size(), emitted_frame_t'{t, eye, tag, 1'b0, 1'b0});
					have_last = 1'b1;
					last_time = t;
					last_eye  = EYE_LEFT;
				end else begin
					// equal keys go after existing entries
					pos = 0;
					while (pos < frame_store.size() && (frame_store[pos].frame_time < t ||
							(frame_store[pos].frame_time == t && frame_store[pos].eye <= eye[0])))
						pos++;
					frame_store.insert(pos, entry_t'{t, eye[0], tag});
					while (front_in_sequence() || frame_store.size() > STORE_CAP) begin
						in_seq = front_in_sequence();
						head = frame_store[0];
						frame_store.delete(0);
						step_out.insert(step_out.size(), emitted_frame_t'{head.frame_time,
							{1'b0, head.eye}, head.tag, !in_seq, 1'b0});
						have_last = 1'b1;
						last_time = head.frame_time;
						last_eye  = head.eye;
					end
				end
			end
			default: ;
		endcase
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].last_of_run = 1'b1;
	endfunction

	task automatic drive_frame(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
			input logic [EYE_W-1:0] eye, input logic [TAG_W-1:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			frames.valid <= 1'b0;
			@(posedge clk);
		end
		frames.valid       <= 1'b1;
		frames.command     <= cmd;
		frames.frame_time  <= t;
		frames.eye         <= eye;
		frames.payload_tag <= tag;
		@(posedge clk);
		while (!frames.ready)
			@(posedge clk);
		if (cmd != CMD_RESERVED)
			n_items++;
		if (cmd == CMD_CLEAR)
			n_clears++;
		if (cmd == CMD_FLUSH)
			n_flushes++;
	endtask

	task automatic send_frame(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
			input logic [EYE_W-1:0] eye, input logic [TAG_W-1:0] tag);
		drive_frame(cmd, t, eye, tag);
		predict_reorder(cmd, t, eye, tag);
		foreach (step_out[i])
			expected_frames.insert(expected_frames.size(), step_out[i]);
	endtask

	// left/right pairs with a few drops, local swaps and pass-through frames mixed in
	task automatic stereo_run();
		logic [TIME_W-1:0] run_times[$];
		logic [EYE_W-1:0]  run_eyes[$];
		logic [TIME_W-1:0] tt;
		logic [EYE_W-1:0]  te;
		int                pairs;
		pairs = $urandom_range(8, 1);
		for (int i = 0; i < pairs; i++) begin
			cur_time = cur_time + TIME_W'($urandom_range(3, 1));
			if ($urandom_range(99) >= 5) begin
				run_times.insert(run_times.size(), cur_time);
				run_eyes.insert(run_eyes.size(), EYE_IN_LEFT);
			end
			if ($urandom_range(99) >= 5) begin
				run_times.insert(run_times.size(), cur_time);
				run_eyes.insert(run_eyes.size(), EYE_IN_RIGHT);
			end
		end
		for (int j = 0; j + 1 < run_times.size(); j++) begin
			if ($urandom_range(2) == 0) begin
				tt = run_times[j];
				te = run_eyes[j];
				run_times[j]     = run_times[j + 1];
				run_eyes[j]      = run_eyes[j + 1];
				run_times[j + 1] = tt;
				run_eyes[j + 1]  = te;
			end
		end
		foreach (run_times[i]) begin
			if ($urandom_range(99) < 8)
				send_frame(CMD_FRAME, cur_time, EYE_IN_OTHER, $urandom);
			send_frame(CMD_FRAME, run_times[i], run_eyes[i], $urandom);
		end
	endtask

	// right frames with no known last frame pile up until the store overflows
	task automatic fill_burst();
		int count;
		count = $urandom_range(40, 34);
		send_frame(CMD_CLEAR, cur_time, EYE_IN_LEFT, $urandom);
		repeat (count)
			send_frame(CMD_FRAME, cur_time + TIME_W'($urandom_range(20)), EYE_IN_RIGHT,
				$urandom);
		cur_time = cur_time + 48'd25;
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(5, 1))
			send_frame(CMD_W'($urandom_range(3)), {16'($urandom), 32'($urandom)},
				EYE_W'($urandom_range(3)), $urandom);
	endtask

	// output side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			results.ready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			results.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			got = '{results.out_time, results.out_eye, results.out_tag, results.overflow,
				results.last_of_run};
			n_results++;
			if (got.overflow === 1'b1)
				n_overflow++;
			if (expected_frames.size() == 0) begin
				report_error($sformatf("result with nothing expected: time %h eye %0d tag %h",
					got.frame_time, got.eye, got.tag));
			end else begin
				want = expected_frames[0];
				expected_frames.delete(0);
				check_field("out_time", 64'(got.frame_time), 64'(want.frame_time));
				check_field("out_eye", 64'(got.eye), 64'(want.eye));
				check_field("out_tag", 64'(got.tag), 64'(want.tag));
				check_field("overflow", 64'(got.overflow), 64'(want.overflow));
				check_field("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if ((frames.valid && frames.ready) || (results.valid && results.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("stereo_eye_reorder_buffer test failed");
			$finish;
		end
	end

	initial begin
		int pick;
		arst_n              <= 1'b0;
		frames.valid        <= 1'b0;
		frames.command      <= CMD_FRAME;
		frames.frame_time   <= '0;
		frames.eye          <= EYE_IN_LEFT;
		frames.payload_tag  <= '0;
		frame_store.delete();
		have_last = 1'b0;
		last_time = '0;
		last_eye  = EYE_LEFT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			drive_frame(DIRECTED_ROWS[r].command, DIRECTED_ROWS[r].frame_time,
				DIRECTED_ROWS[r].eye, DIRECTED_ROWS[r].tag);
			predict_reorder(DIRECTED_ROWS[r].command, DIRECTED_ROWS[r].frame_time,
				DIRECTED_ROWS[r].eye, DIRECTED_ROWS[r].tag);
			if (DIRECTED_ROWS[r].typed)
				expected_frames.insert(expected_frames.size(), DIRECTED_ROWS[r].want);
			else
				foreach (step_out[i])
					expected_frames.insert(expected_frames.size(), step_out[i]);
		end

		cur_time = {1'b0, 15'($urandom), 32'($urandom)};
		while (n_items < ITEM_TARGET) begin
			if (n_items >= 350) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_go = 1'b1;
			end else if (n_items >= 190) begin
				send_idle_pct = 48;
				recv_idle_pct = 29;
			end
			pick = $urandom_range(99);
			if (pick < 55)
				stereo_run();
			else if (pick < 63)
				fill_burst();
			else if (pick < 73)
				send_frame(CMD_FLUSH, {16'($urandom), 32'($urandom)}, EYE_W'($urandom_range(3)),
					$urandom);
			else if (pick < 78)
				send_frame(CMD_CLEAR, {16'($urandom), 32'($urandom)}, EYE_W'($urandom_range(3)),
					$urandom);
			else
				noise_burst();
		end
		frames.valid <= 1'b0;

		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_frames.size() != 0)
			report_error($sformatf("%0d expected results never arrived",
				expected_frames.size()));

		$display("covered %0d input transactions (%0d clears, %0d flushes)",
			n_items, n_clears, n_flushes);
		$display("under idling and a %0d-cycle output hold-off; checked %0d results, %0d overflow, %0d errors",
			HOLD_CYCLES, n_results, n_overflow, n_errors);
		if (n_errors == 0)
			$display("stereo_eye_reorder_buffer test passed");
		else
			$display("stereo_eye_reorder_buffer test failed");
		$finish;
	end

endmodule
